@@ rtl/core/pfd_pkg.sv @@
package pfd_pkg;

    localparam int SqSize = 25;
    localparam int SqSide = 5;

    typedef logic [4:0] code_t;
    typedef logic [4:0] place_t;
    typedef logic [2:0] coord_t;

    localparam code_t NoLetter = 5'd31;
    localparam code_t CodeJ    = 5'd9;

    localparam logic [7:0] AsciiA    = 8'h41;
    localparam logic [7:0] AsciiJ    = 8'h4A;
    localparam logic [7:0] AsciiZ    = 8'h5A;
    localparam logic [7:0] AsciiLowA = 8'h61;
    localparam logic [7:0] AsciiLowZ = 8'h7A;
    localparam logic [7:0] CaseGap   = 8'h20;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_PAIR = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK             = 2'd0,
        STATUS_NOT_IN_SQUARE  = 2'd1,
        STATUS_KEY_INCOMPLETE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic   bad;
        coord_t row;
        coord_t col;
    } lane_info_t;

    typedef struct packed {
        logic   bad;
        place_t addr_a;
        place_t addr_b;
    } merge_out_t;

    function automatic code_t code_of_upper(logic [7:0] c);
        logic [7:0] d;
        d = c - AsciiA;
        if (c < AsciiA || c > AsciiZ)
            return NoLetter;
        else if (c >= AsciiJ)
            return code_t'(d - 8'd1);
        else
            return code_t'(d);
    endfunction

    function automatic logic [7:0] ascii_of_code(code_t k);
        logic [7:0] base;
        base = AsciiA + {3'b000, k};
        if (k < CodeJ)
            return base;
        else
            return base + 8'd1;
    endfunction

    function automatic coord_t place_row(place_t p);
        if (p < place_t'(SqSide))
            return coord_t'(0);
        else if (p < place_t'(2 * SqSide))
            return coord_t'(1);
        else if (p < place_t'(3 * SqSide))
            return coord_t'(2);
        else if (p < place_t'(4 * SqSide))
            return coord_t'(3);
        else
            return coord_t'(4);
    endfunction

    function automatic coord_t place_col(place_t p);
        place_t t;
        t = p - place_t'(place_row(p)) * place_t'(SqSide);
        return coord_t'(t);
    endfunction

    function automatic coord_t wrap_dec(coord_t v);
        if (v == coord_t'(0))
            return coord_t'(SqSide - 1);
        else
            return v - coord_t'(1);
    endfunction

    function automatic place_t join_place(coord_t r, coord_t c);
        return place_t'(r) * place_t'(SqSide) + place_t'(c);
    endfunction

endpackage

@@ rtl/core/pfd_if.sv @@
interface pfd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] letter_a;
    logic [7:0] letter_b;
    logic       key_last;

    modport source (output valid, kind, letter_a, letter_b, key_last, input ready);
    modport sink (input valid, kind, letter_a, letter_b, key_last, output ready);
endinterface

interface pfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_a;
    logic [7:0] plain_b;
    logic [1:0] status;

    modport source (output valid, plain_a, plain_b, status, input ready);
    modport sink (input valid, plain_a, plain_b, status, output ready);
endinterface

@@ rtl/core/playfair_digraph_decrypt.sv @@
// channel  dir  fields                                   per word
// in_ch    in   kind, letter_a, letter_b, key_last       key byte or cipher pair
// out_ch   out  plain_a, plain_b, status                 one per cipher pair
//
// a pair goes through a position lookup, then a square lookup into the output register
// the last key byte starts a walk that fills the rest of the square
// reset restores the plain alphabet square through per entry valid bits, no clear pass
// a pair waits in the merge step while the output register is still held by the sink
module playfair_digraph_decrypt (
    input logic     clk,
    input logic     rst_n,
    pfd_in_if.sink  in_ch,
    pfd_out_if.source out_ch
);
    import pfd_pkg::*;

    state_t            state_reg, state_next;
    logic              kb_reg, kb_next;
    place_t            fill_reg, fill_next;
    logic [SqSize-1:0] used_reg, used_next;
    code_t             walk_reg, walk_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic              pend_reg, pend_next;

    logic              wr_en;
    place_t            wr_place;
    code_t             wr_code;
    logic              pos_en;
    logic              sq_en;
    code_t             addr_a, addr_b;
    place_t            pos_a, pos_b;
    code_t             sq_a, sq_b;
    lane_info_t        info_a, info_b;
    merge_out_t        merged;

    logic [7:0]        key_char;
    code_t             key_code;
    logic [SqSize-1:0] used_eff;
    place_t            fill_eff;

    pfd_lane u_lane_a (
        .clk     (clk),
        .load    (pos_en),
        .letter  (in_ch.letter_a),
        .pos     (pos_a),
        .rd_addr (addr_a),
        .info    (info_a)
    );

    pfd_lane u_lane_b (
        .clk     (clk),
        .load    (pos_en),
        .letter  (in_ch.letter_b),
        .pos     (pos_b),
        .rd_addr (addr_b),
        .info    (info_b)
    );

    pfd_merge u_merge (
        .lane_a (info_a),
        .lane_b (info_b),
        .result (merged)
    );

    pfd_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_place   (wr_place),
        .wr_code    (wr_code),
        .pos_en     (pos_en),
        .pos_addr_a (addr_a),
        .pos_addr_b (addr_b),
        .pos_a      (pos_a),
        .pos_b      (pos_b),
        .sq_en      (sq_en),
        .sq_addr_a  (merged.addr_a),
        .sq_addr_b  (merged.addr_b),
        .sq_a       (sq_a),
        .sq_b       (sq_b)
    );

    // key byte folded to upper case
    assign key_char = (in_ch.letter_a >= AsciiLowA && in_ch.letter_a <= AsciiLowZ)
                      ? in_ch.letter_a - CaseGap : in_ch.letter_a;
    assign key_code = code_of_upper(key_char);
    assign used_eff = kb_reg ? used_reg : '0;
    assign fill_eff = kb_reg ? fill_reg : place_t'(0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kb_reg        <= 1'b0;
            fill_reg      <= place_t'(SqSize);
            used_reg      <= '1;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_OK;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kb_reg        <= kb_next;
            fill_reg      <= fill_next;
            used_reg      <= used_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            pend_reg      <= pend_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kb_next        = kb_reg;
        fill_next      = fill_reg;
        used_next      = used_reg;
        walk_next      = walk_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        pend_next      = pend_reg;
        wr_en          = 1'b0;
        wr_place       = fill_reg;
        wr_code        = walk_reg;
        pos_en         = 1'b0;
        sq_en          = 1'b0;
        in_ch.ready    = 1'b0;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (in_ch.kind == KIND_KEY)
                    begin
                        kb_next   = 1'b1;
                        used_next = used_eff;
                        fill_next = fill_eff;
                        if (key_code != NoLetter && key_char != AsciiJ
                            && fill_eff < place_t'(SqSize) && !used_eff[key_code])
                        begin
                            wr_en               = 1'b1;
                            wr_place            = fill_eff;
                            wr_code             = key_code;
                            used_next[key_code] = 1'b1;
                            fill_next           = fill_eff + place_t'(1);
                        end
                        if (in_ch.key_last)
                        begin
                            walk_next  = '0;
                            state_next = ST_FILL;
                        end
                    end
                    else
                    begin
                        pos_en     = 1'b1;
                        pend_next  = kb_reg;
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_MERGE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    sq_en          = 1'b1;
                    out_valid_next = 1'b1;
                    if (pend_reg)
                        status_next = STATUS_KEY_INCOMPLETE;
                    else if (merged.bad)
                        status_next = STATUS_NOT_IN_SQUARE;
                    else
                        status_next = STATUS_OK;
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                // append the remaining alphabet, one letter checked a cycle
                if (fill_reg < place_t'(SqSize) && !used_reg[walk_reg])
                begin
                    wr_en               = 1'b1;
                    wr_place            = fill_reg;
                    wr_code             = walk_reg;
                    used_next[walk_reg] = 1'b1;
                    fill_next           = fill_reg + place_t'(1);
                end
                if (walk_reg == code_t'(SqSize - 1))
                begin
                    kb_next    = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                    walk_next = walk_reg + code_t'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.status  = status_reg;
    assign out_ch.plain_a = (status_reg == STATUS_OK) ? ascii_of_code(sq_a) : 8'h00;
    assign out_ch.plain_b = (status_reg == STATUS_OK) ? ascii_of_code(sq_b) : 8'h00;

endmodule

@@ rtl/core/pfd_store.sv @@
module pfd_store (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  pfd_pkg::place_t wr_place,
    input  pfd_pkg::code_t  wr_code,
    input  logic            pos_en,
    input  pfd_pkg::code_t  pos_addr_a,
    input  pfd_pkg::code_t  pos_addr_b,
    output pfd_pkg::place_t pos_a,
    output pfd_pkg::place_t pos_b,
    input  logic            sq_en,
    input  pfd_pkg::place_t sq_addr_a,
    input  pfd_pkg::place_t sq_addr_b,
    output pfd_pkg::code_t  sq_a,
    output pfd_pkg::code_t  sq_b
);
    import pfd_pkg::*;

    place_t pos_mem [SqSize];
    code_t  sq_mem  [SqSize];

    logic [SqSize-1:0] pos_vld_reg;
    logic [SqSize-1:0] sq_vld_reg;

    place_t pos_q_a_reg, pos_q_b_reg;
    code_t  pos_addr_a_reg, pos_addr_b_reg;
    logic   pos_hit_a_reg, pos_hit_b_reg;

    code_t  sq_q_a_reg, sq_q_b_reg;
    place_t sq_addr_a_reg, sq_addr_b_reg;
    logic   sq_hit_a_reg, sq_hit_b_reg;

    // entries never written read as the reset square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_vld_reg <= '0;
            sq_vld_reg  <= '0;
        end
        else if (wr_en)
        begin
            pos_vld_reg[wr_code] <= 1'b1;
            sq_vld_reg[wr_place] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_code] <= wr_place;
            sq_mem[wr_place] <= wr_code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_en)
        begin
            pos_q_a_reg    <= pos_mem[pos_addr_a];
            pos_q_b_reg    <= pos_mem[pos_addr_b];
            pos_hit_a_reg  <= pos_vld_reg[pos_addr_a];
            pos_hit_b_reg  <= pos_vld_reg[pos_addr_b];
            pos_addr_a_reg <= pos_addr_a;
            pos_addr_b_reg <= pos_addr_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_en)
        begin
            sq_q_a_reg    <= sq_mem[sq_addr_a];
            sq_q_b_reg    <= sq_mem[sq_addr_b];
            sq_hit_a_reg  <= sq_vld_reg[sq_addr_a];
            sq_hit_b_reg  <= sq_vld_reg[sq_addr_b];
            sq_addr_a_reg <= sq_addr_a;
            sq_addr_b_reg <= sq_addr_b;
        end
    end

    assign pos_a = pos_hit_a_reg ? pos_q_a_reg : pos_addr_a_reg;
    assign pos_b = pos_hit_b_reg ? pos_q_b_reg : pos_addr_b_reg;
    assign sq_a  = sq_hit_a_reg ? sq_q_a_reg : sq_addr_a_reg;
    assign sq_b  = sq_hit_b_reg ? sq_q_b_reg : sq_addr_b_reg;

endmodule

@@ rtl/core/pfd_lane.sv @@
module pfd_lane (
    input  logic                clk,
    input  logic                load,
    input  logic [7:0]          letter,
    input  pfd_pkg::place_t     pos,
    output pfd_pkg::code_t      rd_addr,
    output pfd_pkg::lane_info_t info
);
    import pfd_pkg::*;

    code_t  code;
    place_t place;
    logic   bad_reg;

    assign code    = code_of_upper(letter);
    assign rd_addr = (code == NoLetter) ? code_t'(0) : code;

    always_ff @(posedge clk)
    begin
        if (load)
            bad_reg <= (code == NoLetter);
    end

    assign place    = (pos >= place_t'(SqSize)) ? place_t'(0) : pos;
    assign info.bad = bad_reg;
    assign info.row = place_row(place);
    assign info.col = place_col(place);

endmodule

@@ rtl/core/pfd_merge.sv @@
module pfd_merge (
    input  pfd_pkg::lane_info_t lane_a,
    input  pfd_pkg::lane_info_t lane_b,
    output pfd_pkg::merge_out_t result
);
    import pfd_pkg::*;

    coord_t r1, c1, r2, c2;

    always_comb
    begin
        r1 = lane_a.row;
        c1 = lane_a.col;
        r2 = lane_b.row;
        c2 = lane_b.col;
        priority if (lane_a.row == lane_b.row)
        begin
            c1 = wrap_dec(lane_a.col);
            c2 = wrap_dec(lane_b.col);
        end
        else if (lane_a.col == lane_b.col)
        begin
            r1 = wrap_dec(lane_a.row);
            r2 = wrap_dec(lane_b.row);
        end
        else
        begin
            c1 = lane_b.col;
            c2 = lane_a.col;
        end
    end

    assign result.bad    = lane_a.bad || lane_b.bad;
    assign result.addr_a = join_place(r1, c1);
    assign result.addr_b = join_place(r2, c2);

endmodule

@@ rtl/core/pfd_checker.sv @@
module pfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] plain_a,
    input logic [7:0] plain_b,
    input logic [1:0] status
);
    import pfd_pkg::*;

    // held word stays put while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(plain_a) && $stable(plain_b))
        else $error("output word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_OK || status == STATUS_NOT_IN_SQUARE
            || status == STATUS_KEY_INCOMPLETE)
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> plain_a == 8'h00 && plain_b == 8'h00)
        else $error("error word carries letters");

    a_ok_letters: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK |->
            plain_a >= AsciiA && plain_a <= AsciiZ && plain_a != AsciiJ
            && plain_b >= AsciiA && plain_b <= AsciiZ && plain_b != AsciiJ)
        else $error("plaintext letter outside the square");

endmodule

bind playfair_digraph_decrypt pfd_checker u_pfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .plain_a   (out_ch.plain_a),
    .plain_b   (out_ch.plain_b),
    .status    (out_ch.status)
);
